// ===== rtl/srmdp_pkg.sv =====
// Shared types and codes for the sparse row merge dot product block.
package srmdp_pkg;

    localparam int COLUMN_W = 20;
    localparam int VALUE_W  = 32;
    localparam int SUM_W    = 64;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic [COLUMN_W-1:0]        column;
        logic signed [VALUE_W-1:0]  value;
        logic                       row_end;
    } srmdp_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] dot_product;
        logic                    saturated;
    } srmdp_out_t;

    // Controls from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul;
        logic add;
    } srmdp_mac_ctl_t;

endpackage

// ===== rtl/srmdp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module srmdp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 128
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/srmdp_mac.sv =====
// Registered 32x32 multiplier followed by a saturating 64-bit accumulator.
module srmdp_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  srmdp_pkg::srmdp_mac_ctl_t             ctl,
    input  logic signed [srmdp_pkg::VALUE_W-1:0]  a,
    input  logic signed [srmdp_pkg::VALUE_W-1:0]  b,
    output logic signed [srmdp_pkg::SUM_W-1:0]    sum,
    output logic                                  overflow
);
    import srmdp_pkg::*;

    logic signed [SUM_W-1:0] prod_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    ovf_reg;
    logic                    ovf_next;
    logic signed [SUM_W-1:0] raw_sum;
    logic                    wrap;

    assign raw_sum = sum_reg + prod_reg;
    // Overflow only when both operands share a sign that the result lost.
    assign wrap = (sum_reg[SUM_W-1] == prod_reg[SUM_W-1]) &&
                  (raw_sum[SUM_W-1] != sum_reg[SUM_W-1]);

    always_comb begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (ctl.clear) begin
            sum_next = '0;
            ovf_next = 1'b0;
        end else if (ctl.add) begin
            if (wrap) begin
                sum_next = prod_reg[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
                ovf_next = 1'b1;
            end else begin
                sum_next = raw_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul) begin
            prod_reg <= SUM_W'(a) * SUM_W'(b);
        end
        if (!aresetn) begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
        end
    end

    assign sum      = sum_reg;
    assign overflow = ovf_reg;

endmodule

// ===== rtl/sparse_row_merge_dot_product.sv =====
// A load word is written to the row store as it is taken; a stream word fetches the stored entry
// under the pointer, steps past lower columns, multiplies and adds on a match and then finishes,
// paced by the registered store read. One word at a time; a finished sum waits in an output
// register while the next words are taken, and only a row end stalls while that register is
// still full. Reset (aresetn low, synchronous) empties the stored row, marks the load as done
// and clears the pointer, the sum and the overflow flag; the row store itself is not cleared.
module sparse_row_merge_dot_product #(
    parameter int MAX_ENTRIES = 128,
    parameter int COLUMN_BITS = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  srmdp_pkg::srmdp_in_t    s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output srmdp_pkg::srmdp_out_t   m_data
);
    import srmdp_pkg::*;

    // Address width of the row store and width of counters that must also hold MAX_ENTRIES.
    localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = COLUMN_BITS + VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADD,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;

    // The word being merged is held here while the sequencer walks the stored row.
    logic [COLUMN_BITS-1:0]    col_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic                      row_end_reg;

    logic       m_valid_reg;
    srmdp_out_t m_data_reg;

    logic                   s_accept;
    logic [31:0]            col_wide;
    logic [COLUMN_BITS-1:0] in_col;
    logic [CNT_W-1:0]       cnt_base;
    logic [CNT_W-1:0]       ptr_inc;
    logic                   in_range;
    logic                   out_load;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [COLUMN_BITS-1:0]    rd_col;
    logic signed [VALUE_W-1:0] rd_val;

    srmdp_mac_ctl_t          mac_ctl;
    logic signed [SUM_W-1:0] mac_sum;
    logic                    mac_ovf;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;

    // Only the low COLUMN_BITS of the column take part; a wider setting zero-extends.
    assign col_wide = 32'(s_data.column);
    assign in_col   = col_wide[COLUMN_BITS-1:0];

    // A load word that follows a finished load starts a new row at entry zero.
    assign cnt_base = done_reg ? '0 : count_reg;
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign in_range = (ptr_reg < count_reg);

    assign rd_col = ram_rdata[ENT_W-1:VALUE_W];
    assign rd_val = ram_rdata[VALUE_W-1:0];

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = done_reg;
        ptr_next   = ptr_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_base[AW-1:0];
        ram_wdata  = {in_col, s_data.value};
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[AW-1:0];
        mac_ctl    = '0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_data.operation == OP_LOAD) begin
                        if (done_reg) begin
                            ptr_next      = '0;
                            mac_ctl.clear = 1'b1;
                        end
                        // Entries past the end of the store are dropped; row end still counts.
                        if (cnt_base < CNT_W'(MAX_ENTRIES)) begin
                            ram_we     = 1'b1;
                            count_next = cnt_base + CNT_W'(1);
                        end else begin
                            count_next = cnt_base;
                        end
                        done_next = s_data.row_end;
                    end else begin
                        // Fetch the stored entry under the pointer for the first compare.
                        ram_re     = 1'b1;
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                if (in_range && (rd_col < col_reg)) begin
                    // Stored column is behind: step past it and fetch the next one.
                    ptr_next  = ptr_inc;
                    ram_re    = 1'b1;
                    ram_raddr = ptr_inc[AW-1:0];
                end else if (in_range && (rd_col == col_reg)) begin
                    mac_ctl.mul = 1'b1;
                    state_next  = ST_ADD;
                end else begin
                    // Stored row exhausted or stream column below it: the word adds nothing.
                    state_next = ST_FIN;
                end
            end
            ST_ADD: begin
                mac_ctl.add = 1'b1;
                ptr_next    = ptr_inc;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                if (!row_end_reg) begin
                    state_next = ST_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // Hand the row's sum to the output register and start the next row fresh.
                    out_load      = 1'b1;
                    mac_ctl.clear = 1'b1;
                    ptr_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_reg     <= in_col;
            val_reg     <= s_data.value;
            row_end_reg <= s_data.row_end;
        end
        if (out_load) begin
            m_data_reg.dot_product <= mac_sum;
            m_data_reg.saturated   <= mac_ovf;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            done_reg    <= 1'b1;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            ptr_reg   <= ptr_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    srmdp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_row_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    srmdp_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (mac_ctl),
        .a        (val_reg),
        .b        (rd_val),
        .sum      (mac_sum),
        .overflow (mac_ovf)
    );

endmodule
